// ===== hw/rtl/spm_pkg.sv =====
// Shared widths, latencies and constants for the Stokes polarization metrics block.
// No dependencies; imported by every module of the block.
package spm_pkg;

  localparam int SampleW      = 24;                 // input word width
  localparam int CordicStages = 18;                 // CORDIC micro-rotations
  localparam int DegFrac      = 16;                 // degree fraction bits
  localparam int DegW         = DegFrac + 1;        // degree output width
  localparam int SqW          = 2 * SampleW;        // square / sum of squares
  localparam int RootW        = SampleW + DegFrac;  // isqrt(m << 2*DegFrac)
  localparam int RemW         = RootW + 3;          // isqrt remainder
  localparam int XyW          = SampleW + 3;        // CORDIC x/y
  localparam int AngW         = 24;                 // CORDIC angle, 20 frac bits
  localparam int OutAngW      = 18;                 // output angle, 16 frac bits

  localparam int AngPi     = 3294199;
  localparam int AngHalfPi = 1647099;
  localparam int OutHalfPi = 102944;

  localparam int DegLat = 2 + RootW + DegW;         // magnitude path registers
  localparam int AngLat = CordicStages + 2;         // angle path registers
  localparam int AngPad = DegLat - AngLat;          // angle alignment delay

  // atan(2^-k) in radians, 20 fraction bits
  function automatic logic signed [AngW-1:0] atan_lut(input int k);
    logic signed [AngW-1:0] r;
    unique case (k)
      0:       r = AngW'(823550);
      1:       r = AngW'(486170);
      2:       r = AngW'(256879);
      3:       r = AngW'(130396);
      4:       r = AngW'(65451);
      5:       r = AngW'(32757);
      6:       r = AngW'(16383);
      7:       r = AngW'(8192);
      8:       r = AngW'(4096);
      9:       r = AngW'(2048);
      10:      r = AngW'(1024);
      11:      r = AngW'(512);
      12:      r = AngW'(256);
      13:      r = AngW'(128);
      14:      r = AngW'(64);
      15:      r = AngW'(32);
      16:      r = AngW'(16);
      17:      r = AngW'(8);
      18:      r = AngW'(4);
      19:      r = AngW'(2);
      20:      r = AngW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/stokes_polarization_metrics.sv =====
// Top level: degree and angle of linear polarization plus validity for one Stokes vector.
// Depends on spm_pkg, spm_magnitude and spm_angle.
//
// Usage:
//   Drive stokes_*_i and raise start_i; the word is taken at that clock edge.
//   busy_o is always low: a new word may be started in every cycle.
//   Each word yields one result, shown for one cycle with result_valid_o high,
//   in the order the words were started.
// Path: the squares and the sums are registered, the square root is pipelined
//   by root bit and the divide by I by quotient bit. The CORDIC angle path is
//   delayed to line up with it.
// Throughput: one word per cycle.
// Reset clears only the valid pipeline; no result appears for words not
//   started. The receiver cannot stall, so results are never held back.
module stokes_polarization_metrics import spm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [SampleW-1:0] stokes_i_i,
  input  logic signed [SampleW-1:0] stokes_q_i,
  input  logic signed [SampleW-1:0] stokes_u_i,
  input  logic signed [SampleW-1:0] stokes_v_i,
  output logic                      result_valid_o,
  output logic        [DegW-1:0]    linear_degree_o,
  output logic                      degree_clipped_o,
  output logic signed [OutAngW-1:0] linear_angle_o,
  output logic                      physically_valid_o
);

  logic [DegLat-1:0] vld_q, vld_d;

  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[DegLat-2:0], start_i && !busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign result_valid_o = vld_q[DegLat-1];

  spm_magnitude u_mag (
    .clk_i    (clk_i),
    .i_i      (stokes_i_i),
    .q_i      (stokes_q_i),
    .u_i      (stokes_u_i),
    .v_i      (stokes_v_i),
    .degree_o (linear_degree_o),
    .clip_o   (degree_clipped_o),
    .valid_o  (physically_valid_o)
  );

  logic signed [OutAngW-1:0] ang;
  logic signed [OutAngW-1:0] ang_q [0:AngPad-1];

  spm_angle u_ang (
    .clk_i   (clk_i),
    .q_i     (stokes_q_i),
    .u_i     (stokes_u_i),
    .angle_o (ang)
  );

  // align angle with the longer magnitude path
  always_ff @(posedge clk_i) begin
    ang_q[0] <= ang;
    for (int k = 1; k < AngPad; k++) begin
      ang_q[k] <= ang_q[k-1];
    end
  end

  assign linear_angle_o = ang_q[AngPad-1];

endmodule

// ===== hw/rtl/spm_magnitude.sv =====
// Degree of linear polarization (pipelined isqrt then restoring divide) and validity flag.
// Depends on spm_pkg. The path is DegLat registers deep; one word per cycle.
module spm_magnitude import spm_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [SampleW-1:0] i_i,
  input  logic signed [SampleW-1:0] q_i,
  input  logic signed [SampleW-1:0] u_i,
  input  logic signed [SampleW-1:0] v_i,
  output logic        [DegW-1:0]    degree_o,
  output logic                      clip_o,
  output logic                      valid_o
);

  // stage 1: squares
  logic [SqW-1:0]     ii_q, qq_q, uu_q, vv_q;
  logic [SampleW-1:0] i1_q;
  logic               ipos1_q, inneg1_q;

  always_ff @(posedge clk_i) begin
    ii_q     <= $unsigned(SqW'(i_i) * SqW'(i_i));
    qq_q     <= $unsigned(SqW'(q_i) * SqW'(q_i));
    uu_q     <= $unsigned(SqW'(u_i) * SqW'(u_i));
    vv_q     <= $unsigned(SqW'(v_i) * SqW'(v_i));
    i1_q     <= $unsigned(i_i);
    ipos1_q  <= (i_i > 0);
    inneg1_q <= !i_i[SampleW-1];
  end

  // stage 2 feeds index 0 of the root chain
  logic [SqW-1:0]     m_q    [0:RootW];
  logic [RemW-1:0]    rem_q  [0:RootW];
  logic [RootW-1:0]   root_q [0:RootW];
  logic [SampleW-1:0] dvr_q  [0:RootW];
  logic               pos_q  [0:RootW];
  logic               clip_q [0:RootW];
  logic               vld_q  [0:RootW];

  logic [SqW-1:0] m_d, p_d;
  assign m_d = qq_q + uu_q;
  assign p_d = qq_q + uu_q + vv_q;

  always_ff @(posedge clk_i) begin
    m_q[0]    <= m_d;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    dvr_q[0]  <= i1_q;
    pos_q[0]  <= ipos1_q;
    clip_q[0] <= ({2'b00, m_d} >= {ii_q, 2'b00});
    vld_q[0]  <= inneg1_q && (p_d <= ii_q);
  end

  // one root bit per stage; radicand is m with 2*DegFrac zero bits appended
  for (genvar s = 0; s < RootW; s++) begin : g_root
    localparam int J = RootW - 1 - s;
    logic [1:0]      pair;
    logic [RemW-1:0] rem_n, tst;
    logic            ge;

    if (2 * J >= 2 * DegFrac) begin : g_bits
      assign pair = m_q[s][2*J-2*DegFrac+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_n = {rem_q[s][RemW-3:0], pair};
    assign tst   = RemW'({root_q[s], 2'b01});
    assign ge    = (rem_n >= tst);

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? (rem_n - tst) : rem_n;
      root_q[s+1] <= {root_q[s][RootW-2:0], ge};
      m_q[s+1]    <= m_q[s];
      dvr_q[s+1]  <= dvr_q[s];
      pos_q[s+1]  <= pos_q[s];
      clip_q[s+1] <= clip_q[s];
      vld_q[s+1]  <= vld_q[s];
    end
  end

  // restoring divide of the root by I, one quotient bit per stage
  logic [RootW-1:0]   nrem_q [1:DegW];
  logic [DegW-1:0]    quo_q  [1:DegW];
  logic [SampleW-1:0] dv_q   [1:DegW];
  logic               dpos_q [1:DegW];
  logic               dclp_q [1:DegW];
  logic               dvld_q [1:DegW];

  for (genvar s = 0; s < DegW; s++) begin : g_div
    localparam int B = DegW - 1 - s;
    logic [RootW-1:0]   nr;
    logic [DegW-1:0]    qo;
    logic [SampleW-1:0] dvs;
    logic               dps, dcl, dvl;
    logic [RootW:0]     dsh;
    logic               ge;

    // first stage takes the root chain output directly
    if (s == 0) begin : g_head
      assign nr  = root_q[RootW];
      assign qo  = '0;
      assign dvs = dvr_q[RootW];
      assign dps = pos_q[RootW];
      assign dcl = clip_q[RootW];
      assign dvl = vld_q[RootW];
    end else begin : g_body
      assign nr  = nrem_q[s];
      assign qo  = quo_q[s];
      assign dvs = dv_q[s];
      assign dps = dpos_q[s];
      assign dcl = dclp_q[s];
      assign dvl = dvld_q[s];
    end

    assign dsh = (RootW+1)'(dvs) << B;
    assign ge  = ({1'b0, nr} >= dsh);

    always_ff @(posedge clk_i) begin
      nrem_q[s+1] <= ge ? (nr - dsh[RootW-1:0]) : nr;
      quo_q[s+1]  <= {qo[DegW-2:0], ge};
      dv_q[s+1]   <= dvs;
      dpos_q[s+1] <= dps;
      dclp_q[s+1] <= dcl;
      dvld_q[s+1] <= dvl;
    end
  end

  always_comb begin
    if (!dpos_q[DegW]) begin
      degree_o = '0;
      clip_o   = 1'b0;
    end else if (dclp_q[DegW]) begin
      degree_o = '1;
      clip_o   = 1'b1;
    end else begin
      degree_o = quo_q[DegW];
      clip_o   = 1'b0;
    end
    valid_o = dvld_q[DegW];
  end

endmodule

// ===== hw/rtl/spm_angle.sv =====
// Half of atan2(U, Q): quadrant pre-rotation, pipelined CORDIC vectoring, round and clamp.
// Depends on spm_pkg. The path is AngLat registers deep; one word per cycle.
module spm_angle import spm_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [SampleW-1:0] q_i,
  input  logic signed [SampleW-1:0] u_i,
  output logic signed [OutAngW-1:0] angle_o
);

  logic signed [XyW-1:0]  x_q [0:CordicStages];
  logic signed [XyW-1:0]  y_q [0:CordicStages];
  logic signed [AngW-1:0] z_q [0:CordicStages];
  logic                   uz_q [0:CordicStages];
  logic                   qn_q [0:CordicStages];

  logic signed [XyW-1:0]  qx, ux, x_d, y_d;
  logic signed [AngW-1:0] z_d;

  assign qx = XyW'(q_i);
  assign ux = XyW'(u_i);

  // move left half plane vectors into the right half plane
  always_comb begin
    if (q_i < 0) begin
      if (u_i > 0) begin
        x_d = ux;
        y_d = -qx;
        z_d = AngW'(AngHalfPi);
      end else begin
        x_d = -ux;
        y_d = qx;
        z_d = -AngW'(AngHalfPi);
      end
    end else begin
      x_d = qx;
      y_d = ux;
      z_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]  <= x_d;
    y_q[0]  <= y_d;
    z_q[0]  <= z_d;
    uz_q[0] <= (u_i == '0);
    qn_q[0] <= q_i[SampleW-1];
  end

  for (genvar k = 0; k < CordicStages; k++) begin : g_rot
    logic signed [XyW-1:0] xs, ys;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (!y_q[k][XyW-1]) begin
        x_q[k+1] <= x_q[k] + ys;
        y_q[k+1] <= y_q[k] - xs;
        z_q[k+1] <= z_q[k] + atan_lut(k);
      end else begin
        x_q[k+1] <= x_q[k] - ys;
        y_q[k+1] <= y_q[k] + xs;
        z_q[k+1] <= z_q[k] - atan_lut(k);
      end
      uz_q[k+1] <= uz_q[k];
      qn_q[k+1] <= qn_q[k];
    end
  end

  logic signed [AngW-1:0]    zc, hs;
  logic signed [OutAngW-1:0] ang_d, ang_q;

  always_comb begin
    zc = z_q[CordicStages];
    if (zc > AngW'(AngPi)) zc = AngW'(AngPi);
    if (zc < -AngW'(AngPi)) zc = -AngW'(AngPi);
    // halve and drop 4 fraction bits, ties upward
    hs = (zc + AngW'(16)) >>> 5;
    if (hs > AngW'(OutHalfPi)) hs = AngW'(OutHalfPi);
    if (hs < -AngW'(OutHalfPi)) hs = -AngW'(OutHalfPi);
    if (uz_q[CordicStages]) begin
      ang_d = qn_q[CordicStages] ? OutAngW'(OutHalfPi) : '0;
    end else begin
      ang_d = hs[OutAngW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= ang_d;
  end

  assign angle_o = ang_q;

endmodule

// ===== bench/stokes_polarization_metrics_checker.sv =====
// Result checker for stokes_polarization_metrics: predicts degree, angle and
// validity for every started word and compares them with the result strobe.
// Depends on spm_pkg.
module stokes_polarization_metrics_checker import spm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic signed [SampleW-1:0] stokes_i_i,
  input  logic signed [SampleW-1:0] stokes_q_i,
  input  logic signed [SampleW-1:0] stokes_u_i,
  input  logic signed [SampleW-1:0] stokes_v_i,
  input  logic                      result_valid_i,
  input  logic        [DegW-1:0]    linear_degree_i,
  input  logic                      degree_clipped_i,
  input  logic signed [OutAngW-1:0] linear_angle_i,
  input  logic                      physically_valid_i,
  output int                        pending_o,
  output int                        errors_o
);

  typedef struct packed {
    logic        [DegW-1:0]    degree;
    logic                      clipped;
    logic signed [OutAngW-1:0] angle;
    logic                      valid;
  } metrics_t;

  metrics_t expected_q[$];

  localparam longint AtanTab[24] = '{823550, 486170, 256879, 130396, 65451, 32757,
    16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

  function automatic metrics_t predict_metrics(longint si, longint sq, longint su,
                                               longint sv);
    metrics_t r;
    logic [127:0] m, ui, c, t;
    longint x, y, z, xs, ys, h;
    r = '0;
    // degree: largest d with (d*I)^2 <= m << 32
    if (si > 0) begin
      m = 128'(sq * sq + su * su);
      ui = 128'(si);
      if (m >= 4 * ui * ui) begin
        r.degree = '1;
        r.clipped = 1'b1;
      end else begin
        for (int b = 16; b >= 0; b--) begin
          c = r.degree | (128'd1 << b);
          t = c * ui;
          if (t * t <= (m << 32)) r.degree = c[DegW-1:0];
        end
      end
    end
    // angle: CORDIC vectoring, halved and rounded
    if (su == 0) begin
      r.angle = (sq < 0) ? OutAngW'(OutHalfPi) : '0;
    end else begin
      if (sq < 0) begin
        if (su > 0) begin
          x = su; y = -sq; z = AngHalfPi;
        end else begin
          x = -su; y = sq; z = -AngHalfPi;
        end
      end else begin
        x = sq; y = su; z = 0;
      end
      for (int k = 0; k < CordicStages && k < 24; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (y >= 0) begin
          x += ys; y -= xs; z += AtanTab[k];
        end else begin
          x -= ys; y += xs; z -= AtanTab[k];
        end
      end
      if (z > AngPi) z = AngPi;
      if (z < -AngPi) z = -AngPi;
      h = (z + 16) >>> 5;
      if (h > OutHalfPi) h = OutHalfPi;
      if (h < -OutHalfPi) h = -OutHalfPi;
      r.angle = h[OutAngW-1:0];
    end
    r.valid = (si >= 0) && (sq * sq + su * su + sv * sv <= si * si);
    return r;
  endfunction

  always @(posedge clk_i) begin
    metrics_t got, want;
    if (!rst_ni) begin
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (result_valid_i) begin
        got = '{linear_degree_i, degree_clipped_i, linear_angle_i, physically_valid_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.degree !== want.degree)
            $display("%0t: degree exp %0d got %0d", $time, want.degree, got.degree);
          if (got.clipped !== want.clipped)
            $display("%0t: clip exp %0d got %0d", $time, want.clipped, got.clipped);
          if (got.angle !== want.angle)
            $display("%0t: angle exp %0d got %0d", $time, want.angle, got.angle);
          if (got.valid !== want.valid)
            $display("%0t: valid exp %0d got %0d", $time, want.valid, got.valid);
          if (got !== want) errors_o <= errors_o + 1;
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(predict_metrics(stokes_i_i, stokes_q_i, stokes_u_i,
                                             stokes_v_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== bench/stokes_polarization_metrics_tb.sv =====
// Testbench top for stokes_polarization_metrics: directed and random Stokes
// words with random gaps; depends on spm_pkg and the result checker.
module stokes_polarization_metrics_tb import spm_pkg::*;;

  localparam int MaxS = 8388607;
  localparam int MinS = -8388608;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [SampleW-1:0] stokes_i_i = '0, stokes_q_i = '0;
  logic signed [SampleW-1:0] stokes_u_i = '0, stokes_v_i = '0;
  logic result_valid_o, degree_clipped_o, physically_valid_o;
  logic [DegW-1:0] linear_degree_o;
  logic signed [OutAngW-1:0] linear_angle_o;
  int pending, errors;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  stokes_polarization_metrics uut (.*);

  stokes_polarization_metrics_checker checker_u (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .stokes_i_i, .stokes_q_i, .stokes_u_i, .stokes_v_i,
    .result_valid_i(result_valid_o), .linear_degree_i(linear_degree_o),
    .degree_clipped_i(degree_clipped_o), .linear_angle_i(linear_angle_o),
    .physically_valid_i(physically_valid_o),
    .pending_o(pending), .errors_o(errors)
  );

  // one word, then a random gap (none during burst stretches)
  task automatic send_word(int si, int sq, int su, int sv, bit burst);
    int gap;
    stokes_i_i <= SampleW'(si);
    stokes_q_i <= SampleW'(sq);
    stokes_u_i <= SampleW'(su);
    stokes_v_i <= SampleW'(sv);
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    gap = burst ? 0 : $urandom_range(8, 0);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic int rand_sample(int scale);
    int v;
    case ($urandom_range(3, 0))
      0: v = $urandom;
      1: v = $signed($urandom_range(2 * scale, 0)) - scale;
      2: v = $urandom_range(1, 0) ? MaxS : MinS;
      default: v = $signed($urandom_range(64, 0)) - 32;
    endcase
    return $signed(v[SampleW-1:0]);
  endfunction

  initial begin
    int si, sq, su, sv, scale;
    bit burst;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: extremes, zero vector, zero U both signs of Q, nonpositive I, clip
    send_word(0, 0, 0, 0, 0);
    send_word(MaxS, MaxS, MaxS, MaxS, 0);
    send_word(MinS, MinS, MinS, MinS, 0);
    send_word(1 << 20, 5000, 0, 0, 0);
    send_word(1 << 20, -5000, 0, 0, 0);
    send_word(1 << 20, MinS, 0, 0, 0);
    send_word(-1, 100, 100, 0, 0);
    send_word(0, 100, -100, 0, 0);
    send_word(1, MaxS, MinS, 0, 0);
    send_word(1000, 2000, 0, 0, 0);
    send_word(1000, 1999, 0, 0, 0);
    send_word(1000, 600, 800, 0, 0);
    send_word(1000, 600, 800, 1, 0);
    send_word(MaxS, -1, 1, -1, 0);
    send_word(MaxS, -1, -1, 0, 0);
    send_word(MaxS, 1, -1, 0, 0);
    send_word(MaxS, 0, MaxS, 0, 0);
    send_word(MaxS, 0, MinS, 0, 0);
    send_word(1 << 20, -(1 << 20), 1, 0, 0);
    send_word(1 << 20, -(1 << 20), -1, 0, 0);
    // hold off until the pipeline drains
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    for (int n = 0; n < 1100; n++) begin
      if (n % 100 == 0) burst = $urandom_range(1, 0);
      scale = 1 << $urandom_range(23, 2);
      si = rand_sample(scale);
      sq = rand_sample(scale);
      su = rand_sample(scale);
      sv = rand_sample(scale);
      // mostly physical-ish vectors: I dominates
      if ($urandom_range(3, 0) != 0) begin
        si = $urandom_range(MaxS, 0);
        sq = $signed(sq) >>> $urandom_range(3, 0);
        su = $signed(su) >>> $urandom_range(3, 0);
      end
      send_word(si, sq, su, sv, burst);
    end
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DegLat + 10) @(negedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
